### sv/tga_pkg.sv
// shared types and constants of the tga stream decoder
// used by the front, queue, back and top modules; no dependencies
package tga_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ID,
    PH_PIXELS,
    PH_DRAIN
  } phase_e;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_RUN    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ST_BAD_OFFSET  = 3'd3;
  localparam logic [2:0] ST_TRUNCATED   = 3'd4;
  localparam logic [2:0] ST_RUN_CUT     = 3'd5;
  localparam logic [2:0] ST_RAW_CUT     = 3'd6;
  localparam logic [2:0] ST_EARLY_END   = 3'd7;

  localparam logic [4:0] HDR_LAST = 5'd17;

  localparam logic [7:0] TYPE_TRUE = 8'd2;
  localparam logic [7:0] TYPE_GREY = 8'd3;
  localparam logic [7:0] TYPE_RLE  = 8'd10;

  localparam logic [7:0] BPP_8  = 8'd8;
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;

  localparam logic [7:0] TOP_ORIGIN_BIT = 8'h20;

  // one word of the queue: the results caused by one input byte
  typedef struct packed {
    logic [1:0]  a_kind;
    logic [2:0]  a_status;
    logic [31:0] texel;
    logic [7:0]  len;
    logic        has_b;
    logic [2:0]  b_status;
    logic [15:0] width;
    logic [15:0] height;
    logic        top;
  } entry_t;

endpackage

### sv/tga_front.sv
// front part: header parsing, format checks and packet / pixel assembly
// depends on tga_pkg; emits one queue word per byte that causes results
module tga_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_file_i,
  output logic              push_o,
  output tga_pkg::entry_t   entry_o
);

  tga_pkg::phase_e phase_q, phase_d;
  logic [4:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  id_left_q, id_left_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  bpp_q, bpp_d;
  logic        top_q, top_d;
  logic        cmap_q, cmap_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [31:0] pix_left_q, pix_left_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic        pkt_run_q, pkt_run_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [23:0] asm_q, asm_d;

  logic        has_a;
  logic        fmt_ok;
  logic        rle;
  logic        done_px;
  logic [7:0]  r, g, bl, al;
  logic [7:0]  run_len;
  logic [2:0]  st;
  logic        st_valid;

  assign rle = (kind_q == tga_pkg::TYPE_RLE);

  always_comb begin
    phase_d    = phase_q;
    hdr_idx_d  = hdr_idx_q;
    id_left_d  = id_left_q;
    kind_d     = kind_q;
    bpp_d      = bpp_q;
    top_d      = top_q;
    cmap_d     = cmap_q;
    width_d    = width_q;
    height_d   = height_q;
    pix_left_d = pix_left_q;
    pkt_left_d = pkt_left_q;
    pkt_run_d  = pkt_run_q;
    byte_idx_d = byte_idx_q;
    asm_d      = asm_q;
    has_a      = 1'b0;
    st         = tga_pkg::ST_OK;
    st_valid   = 1'b0;
    entry_o    = '0;
    fmt_ok     = 1'b0;
    done_px    = 1'b0;
    r  = 8'd0;
    g  = 8'd0;
    bl = 8'd0;
    al = 8'hff;
    run_len = 8'd1;

    unique case (phase_q)
      tga_pkg::PH_HEADER: begin
        unique case (hdr_idx_q)
          5'd0:  id_left_d = data_byte_i;
          5'd1:  cmap_d = (data_byte_i != 8'd0);
          5'd2:  kind_d = data_byte_i;
          5'd12: width_d = {width_q[15:8], data_byte_i};
          5'd13: width_d = {data_byte_i, width_q[7:0]};
          5'd14: height_d = {height_q[15:8], data_byte_i};
          5'd15: height_d = {data_byte_i, height_q[7:0]};
          5'd16: bpp_d = data_byte_i;
          5'd17: top_d = ((data_byte_i & tga_pkg::TOP_ORIGIN_BIT) != 8'd0);
          default: ;
        endcase
        hdr_idx_d = hdr_idx_q + 5'd1;
        if (hdr_idx_q >= tga_pkg::HDR_LAST) begin
          fmt_ok = !cmap_q && (width_q != 16'd0) && (height_q != 16'd0) &&
                   (kind_q == tga_pkg::TYPE_TRUE || kind_q == tga_pkg::TYPE_GREY ||
                    kind_q == tga_pkg::TYPE_RLE) &&
                   (bpp_q == tga_pkg::BPP_8 || bpp_q == tga_pkg::BPP_24 ||
                    bpp_q == tga_pkg::BPP_32);
          if (!fmt_ok) begin
            st_valid = 1'b1;
            st       = tga_pkg::ST_UNSUPPORTED;
            phase_d  = tga_pkg::PH_DRAIN;
          end else begin
            has_a           = 1'b1;
            entry_o.a_kind  = tga_pkg::KIND_HEADER;
            pix_left_d      = 32'(width_q) * 32'(height_q);
            phase_d         = (id_left_q != 8'd0) ? tga_pkg::PH_ID : tga_pkg::PH_PIXELS;
            if (end_of_file_i) begin
              st_valid = 1'b1;
              st       = tga_pkg::ST_BAD_OFFSET;
            end
          end
        end else if (end_of_file_i) begin
          st_valid = 1'b1;
          st       = tga_pkg::ST_SHORT_HDR;
        end
      end
      tga_pkg::PH_ID: begin
        id_left_d = id_left_q - 8'd1;
        if (id_left_d == 8'd0) phase_d = tga_pkg::PH_PIXELS;
        if (end_of_file_i) begin
          st_valid = 1'b1;
          st       = tga_pkg::ST_BAD_OFFSET;
        end
      end
      tga_pkg::PH_PIXELS: begin
        if (rle && pkt_left_q == 8'd0) begin
          pkt_left_d = {1'b0, data_byte_i[6:0]} + 8'd1;
          pkt_run_d  = data_byte_i[7];
          if (end_of_file_i) begin
            st_valid = 1'b1;
            st       = data_byte_i[7] ? tga_pkg::ST_RUN_CUT : tga_pkg::ST_RAW_CUT;
          end
        end else begin
          done_px = ({3'd0, byte_idx_q} + 5'd1) >= bpp_q[7:3];
          if (done_px) begin
            if (bpp_q == tga_pkg::BPP_8) begin
              r  = data_byte_i;
              g  = data_byte_i;
              bl = data_byte_i;
            end else if (bpp_q == tga_pkg::BPP_24) begin
              bl = asm_q[7:0];
              g  = asm_q[15:8];
              r  = data_byte_i;
            end else begin
              bl = asm_q[7:0];
              g  = asm_q[15:8];
              r  = asm_q[23:16];
              al = data_byte_i;
            end
            byte_idx_d = 2'd0;
            asm_d      = 24'd0;
            if (rle && pkt_run_q) begin
              run_len    = ({24'd0, pkt_left_q} < pix_left_q) ? pkt_left_q : pix_left_q[7:0];
              pkt_left_d = 8'd0;
            end else begin
              run_len = 8'd1;
              if (rle) pkt_left_d = pkt_left_q - 8'd1;
            end
            has_a          = 1'b1;
            entry_o.a_kind = tga_pkg::KIND_RUN;
            entry_o.texel  = {al, bl, g, r};
            entry_o.len    = run_len;
            pix_left_d     = pix_left_q - {24'd0, run_len};
            if (pix_left_d == 32'd0) begin
              st_valid = 1'b1;
              st       = tga_pkg::ST_OK;
              phase_d  = tga_pkg::PH_DRAIN;
            end else if (end_of_file_i) begin
              st_valid = 1'b1;
              st = !rle ? tga_pkg::ST_TRUNCATED :
                   ((pkt_left_d != 8'd0) ? tga_pkg::ST_RAW_CUT : tga_pkg::ST_EARLY_END);
            end
          end else begin
            case (byte_idx_q)
              2'd0:    asm_d = asm_q | {16'd0, data_byte_i};
              2'd1:    asm_d = asm_q | {8'd0, data_byte_i, 8'd0};
              2'd2:    asm_d = asm_q | {data_byte_i, 16'd0};
              default: asm_d = asm_q;
            endcase
            byte_idx_d = byte_idx_q + 2'd1;
            if (end_of_file_i) begin
              st_valid = 1'b1;
              st = !rle ? tga_pkg::ST_TRUNCATED :
                   (pkt_run_q ? tga_pkg::ST_RUN_CUT : tga_pkg::ST_RAW_CUT);
            end
          end
        end
      end
      tga_pkg::PH_DRAIN: ;
      default: ;
    endcase

    // a status alone goes into the first slot, after a result into the second
    if (st_valid) begin
      if (has_a) begin
        entry_o.has_b    = 1'b1;
        entry_o.b_status = st;
      end else begin
        entry_o.a_kind   = tga_pkg::KIND_STATUS;
        entry_o.a_status = st;
      end
    end
    entry_o.width  = width_d;
    entry_o.height = height_d;
    entry_o.top    = top_d;
    push_o = accept_i && (has_a || st_valid);

    if (end_of_file_i) begin
      phase_d    = tga_pkg::PH_HEADER;
      hdr_idx_d  = 5'd0;
      id_left_d  = 8'd0;
      kind_d     = 8'd0;
      bpp_d      = 8'd0;
      top_d      = 1'b0;
      cmap_d     = 1'b0;
      width_d    = 16'd0;
      height_d   = 16'd0;
      pix_left_d = 32'd0;
      pkt_left_d = 8'd0;
      pkt_run_d  = 1'b0;
      byte_idx_d = 2'd0;
      asm_d      = 24'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tga_pkg::PH_HEADER;
      hdr_idx_q  <= 5'd0;
      id_left_q  <= 8'd0;
      kind_q     <= 8'd0;
      bpp_q      <= 8'd0;
      top_q      <= 1'b0;
      cmap_q     <= 1'b0;
      width_q    <= 16'd0;
      height_q   <= 16'd0;
      pix_left_q <= 32'd0;
      pkt_left_q <= 8'd0;
      pkt_run_q  <= 1'b0;
      byte_idx_q <= 2'd0;
      asm_q      <= 24'd0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      hdr_idx_q  <= hdr_idx_d;
      id_left_q  <= id_left_d;
      kind_q     <= kind_d;
      bpp_q      <= bpp_d;
      top_q      <= top_d;
      cmap_q     <= cmap_d;
      width_q    <= width_d;
      height_q   <= height_d;
      pix_left_q <= pix_left_d;
      pkt_left_q <= pkt_left_d;
      pkt_run_q  <= pkt_run_d;
      byte_idx_q <= byte_idx_d;
      asm_q      <= asm_d;
    end
  end

endmodule

### sv/tga_queue.sv
// two-word queue between the front and the back part
// depends on tga_pkg for the word type
module tga_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tga_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output tga_pkg::entry_t head_o
);

  tga_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### sv/tga_back.sv
// back part: position tracking, run division and the output register
// depends on tga_pkg; pops words from tga_queue
module tga_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  tga_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      item_kind_o,
  output logic [31:0]     texel_o,
  output logic [15:0]     start_x_o,
  output logic [15:0]     start_y_o,
  output logic [7:0]      run_length_o,
  output logic            rows_descend_o,
  output logic [15:0]     image_width_o,
  output logic [15:0]     image_height_o,
  output logic [2:0]      status_o,
  output logic            last_of_step_o
);

  logic        valid_q;
  logic        sel_q, sel_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] texel_q, texel_d;
  logic [15:0] x_q, x_d, y_q, y_d;
  logic [7:0]  len_q, len_d;
  logic        desc_q, desc_d;
  logic [15:0] w_q, w_d, h_q, h_d;
  logic [2:0]  st_q, st_d;
  logic        last_q, last_d;

  logic [15:0] col_q, col_d, row_q, row_d;
  logic        busy_q, busy_d;
  logic [23:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [7:0]  quo_q, quo_d;
  logic [2:0]  step_q, step_d;

  logic        can_load, load;
  logic [23:0] shifted;
  logic [16:0] total1;

  assign can_load = !valid_q || !out_stall_i;
  assign shifted  = {8'd0, dvs_q} << step_q;
  assign total1   = {1'b0, col_q} + 17'd1;

  always_comb begin
    sel_d  = sel_q;
    kind_d = kind_q;  texel_d = texel_q; x_d = x_q; y_d = y_q; len_d = len_q;
    desc_d = desc_q;  w_d = w_q; h_d = h_q; st_d = st_q; last_d = last_q;
    col_d  = col_q;   row_d = row_q;
    busy_d = busy_q;  rem_d = rem_q; dvs_d = dvs_q; quo_d = quo_q; step_d = step_q;
    pop_o  = 1'b0;
    load   = 1'b0;

    // restoring division of the run end by the width, one quotient bit a cycle
    if (busy_q) begin
      if (rem_q >= shifted) begin
        rem_d = rem_q - shifted;
        quo_d = quo_q | (8'd1 << step_q);
      end
      step_d = step_q - 3'd1;
      if (step_q == 3'd0) begin
        busy_d = 1'b0;
        col_d  = rem_d[15:0];
        row_d  = row_q + {8'd0, quo_d};
      end
    end

    if (!empty_i && can_load) begin
      desc_d = !head_i.top;
      w_d    = head_i.width;
      h_d    = head_i.height;
      if (sel_q) begin
        load   = 1'b1;
        kind_d = tga_pkg::KIND_STATUS;
        texel_d = 32'd0; x_d = 16'd0; y_d = 16'd0; len_d = 8'd0;
        st_d   = head_i.b_status;
        last_d = 1'b1;
        sel_d  = 1'b0;
        pop_o  = 1'b1;
      end else if (!busy_q) begin
        load    = 1'b1;
        kind_d  = head_i.a_kind;
        texel_d = 32'd0; x_d = 16'd0; y_d = 16'd0; len_d = 8'd0;
        st_d    = head_i.a_status;
        last_d  = !head_i.has_b;
        if (head_i.has_b) sel_d = 1'b1;
        else pop_o = 1'b1;
        if (head_i.a_kind == tga_pkg::KIND_HEADER) begin
          col_d = 16'd0;
          row_d = 16'd0;
        end else if (head_i.a_kind == tga_pkg::KIND_RUN) begin
          texel_d = head_i.texel;
          len_d   = head_i.len;
          x_d     = col_q;
          y_d     = head_i.top ? row_q : (head_i.height - 16'd1 - row_q);
          st_d    = tga_pkg::ST_OK;
          if (head_i.len == 8'd1) begin
            if (total1 == {1'b0, head_i.width}) begin
              col_d = 16'd0;
              row_d = row_q + 16'd1;
            end else begin
              col_d = total1[15:0];
            end
          end else begin
            busy_d = 1'b1;
            rem_d  = {8'd0, col_q} + {16'd0, head_i.len};
            dvs_d  = head_i.width;
            quo_d  = 8'd0;
            step_d = 3'd7;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
      busy_q  <= 1'b0;
      col_q   <= 16'd0;
      row_q   <= 16'd0;
      step_q  <= 3'd0;
    end else begin
      if (load) valid_q <= 1'b1;
      else if (!out_stall_i) valid_q <= 1'b0;
      sel_q  <= sel_d;
      busy_q <= busy_d;
      col_q  <= col_d;
      row_q  <= row_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    if (load) begin
      kind_q  <= kind_d;
      texel_q <= texel_d;
      x_q     <= x_d;
      y_q     <= y_d;
      len_q   <= len_d;
      desc_q  <= desc_d;
      w_q     <= w_d;
      h_q     <= h_d;
      st_q    <= st_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign item_kind_o    = kind_q;
  assign texel_o        = texel_q;
  assign start_x_o      = x_q;
  assign start_y_o      = y_q;
  assign run_length_o   = len_q;
  assign rows_descend_o = desc_q;
  assign image_width_o  = w_q;
  assign image_height_o = h_q;
  assign status_o       = st_q;
  assign last_of_step_o = last_q;

endmodule

### sv/tga_image_stream_decoder.sv
// top level of the tga stream decoder
// depends on tga_pkg, tga_front, tga_queue and tga_back
//
// usage
// - input channel: one file byte per word (data_byte_i, end_of_file_i on the
//   last byte), in_valid_i / in_stall_o; a word moves when valid is high and
//   stall is low
// - output channel: one result per word, out_valid_o / out_stall_i, fields
//   as separate ports; a byte gives zero, one or two results
// - the front part takes one byte a cycle while the two-word queue has room;
//   header, id, raw pixel and single-pixel bytes sustain one byte per cycle
// - a run longer than one pixel starts a division of the run end by the
//   width in the back part; the next run result waits for it, so a file
//   with many such runs holds the input back once the queue fills
// - a byte's first result is held in the queue, then in the output register
// - reset clears the parser, the queue and the output register; the decoder
//   then expects the first header byte
// - when the receiver stalls, the output word holds, the queue fills and
//   in_stall_o rises; no result is lost or repeated
// - after a byte with end_of_file_i set the parser returns to the header
//   phase at once, while older results still drain from the queue
module tga_image_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic [31:0] texel_o,
  output logic [15:0] start_x_o,
  output logic [15:0] start_y_o,
  output logic [7:0]  run_length_o,
  output logic        rows_descend_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [2:0]  status_o,
  output logic        last_of_step_o
);

  logic            q_full, q_empty, push, pop, accept;
  tga_pkg::entry_t push_entry, head_entry;

  // stall only on a full queue, so a byte is taken while a result waits
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  tga_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .end_of_file_i(end_of_file_i),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  tga_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (head_entry)
  );

  tga_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .item_kind_o   (item_kind_o),
    .texel_o       (texel_o),
    .start_x_o     (start_x_o),
    .start_y_o     (start_y_o),
    .run_length_o  (run_length_o),
    .rows_descend_o(rows_descend_o),
    .image_width_o (image_width_o),
    .image_height_o(image_height_o),
    .status_o      (status_o),
    .last_of_step_o(last_of_step_o)
  );

endmodule

### tb/sv/tb_tga_image_stream_decoder.sv
// self-checking testbench of the tga stream decoder: directed and random files
// are pushed byte by byte and every result is checked against a local decoder
// depends on tga_pkg and tga_image_stream_decoder
module tb_tga_image_stream_decoder;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] texel;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  len;
    logic        desc;
    logic [15:0] w;
    logic [15:0] h;
    logic [2:0]  status;
    logic        last;
  } tga_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       hold;   // wait for every pending result before this word
  } file_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  item_kind_o;
  logic [31:0] texel_o;
  logic [15:0] start_x_o;
  logic [15:0] start_y_o;
  logic [7:0]  run_length_o;
  logic        rows_descend_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic [2:0]  status_o;
  logic        last_of_step_o;

  tga_image_stream_decoder u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  file_byte_t  byte_q[$];
  tga_result_t result_q[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          stim_done = 0;

  // local copy of the decoder state
  tga_pkg::phase_e dec_phase;
  logic [4:0]  hdr_idx;
  logic [7:0]  id_left;
  logic [7:0]  img_kind;
  logic [7:0]  bpp;
  logic        top_org;
  logic        cmap;
  logic [15:0] wid;
  logic [15:0] hgt;
  logic [31:0] px_left;
  logic [15:0] col;
  logic [15:0] row;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [1:0]  px_idx;
  logic [23:0] px_acc;

  function automatic void clear_decoder();
    dec_phase = tga_pkg::PH_HEADER;
    hdr_idx = '0; id_left = '0; img_kind = '0; bpp = '0; top_org = 1'b0;
    cmap = 1'b0; wid = '0; hgt = '0; px_left = '0; col = '0; row = '0;
    pkt_left = '0; pkt_run = 1'b0; px_idx = '0; px_acc = '0;
  endfunction

  function automatic tga_result_t make_result(logic [1:0] kind, logic [31:0] texel,
                                              logic [15:0] x, logic [15:0] y,
                                              logic [7:0] len, logic [2:0] st);
    tga_result_t r;
    r = '{kind, texel, x, y, len, ~top_org, wid, hgt, st, 1'b0};
    return r;
  endfunction

  // one run result, then advance the raster position
  function automatic tga_result_t texel_run(logic [31:0] texel, logic [31:0] len);
    tga_result_t r;
    logic [31:0] y;
    logic [31:0] total;
    y = top_org ? {16'd0, row} : ({16'd0, hgt} - 32'd1 - {16'd0, row});
    r = make_result(tga_pkg::KIND_RUN, texel, col, y[15:0], len[7:0], tga_pkg::ST_OK);
    total = {16'd0, col} + len;
    if (wid != 0) begin
      row = row + 16'(total / wid);
      col = 16'(total % wid);
    end
    px_left = px_left - len;
    return r;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eof);
    tga_result_t r[$];
    logic        ok;
    logic        rle;
    logic [31:0] texel;
    logic [31:0] len;
    logic [2:0]  st;
    rle = (img_kind == tga_pkg::TYPE_RLE);
    case (dec_phase)
      tga_pkg::PH_HEADER: begin
        case (hdr_idx)
          5'd0:  id_left = b;
          5'd1:  cmap = (b != 0);
          5'd2:  img_kind = b;
          5'd12: wid[7:0] = b;
          5'd13: wid[15:8] = b;
          5'd14: hgt[7:0] = b;
          5'd15: hgt[15:8] = b;
          5'd16: bpp = b;
          5'd17: top_org = (b & tga_pkg::TOP_ORIGIN_BIT) != 0;
          default: ;
        endcase
        if (hdr_idx >= tga_pkg::HDR_LAST) begin
          ok = !cmap && wid != 0 && hgt != 0 &&
               (img_kind == tga_pkg::TYPE_TRUE || img_kind == tga_pkg::TYPE_GREY ||
                img_kind == tga_pkg::TYPE_RLE) &&
               (bpp == tga_pkg::BPP_8 || bpp == tga_pkg::BPP_24 || bpp == tga_pkg::BPP_32);
          if (!ok) begin
            r.push_back(make_result(tga_pkg::KIND_STATUS, 0, 0, 0, 0,
                                    tga_pkg::ST_UNSUPPORTED));
            dec_phase = tga_pkg::PH_DRAIN;
          end else begin
            r.push_back(make_result(tga_pkg::KIND_HEADER, 0, 0, 0, 0, tga_pkg::ST_OK));
            px_left = 32'(wid) * 32'(hgt);
            dec_phase = (id_left != 0) ? tga_pkg::PH_ID : tga_pkg::PH_PIXELS;
            if (eof) r.push_back(make_result(tga_pkg::KIND_STATUS, 0, 0, 0, 0,
                                             tga_pkg::ST_BAD_OFFSET));
          end
        end else if (eof) begin
          r.push_back(make_result(tga_pkg::KIND_STATUS, 0, 0, 0, 0, tga_pkg::ST_SHORT_HDR));
        end
        hdr_idx = hdr_idx + 5'd1;
      end
      tga_pkg::PH_ID: begin
        id_left = id_left - 8'd1;
        if (id_left == 0) dec_phase = tga_pkg::PH_PIXELS;
        if (eof) r.push_back(make_result(tga_pkg::KIND_STATUS, 0, 0, 0, 0,
                                         tga_pkg::ST_BAD_OFFSET));
      end
      tga_pkg::PH_PIXELS: begin
        if (rle && pkt_left == 0) begin
          pkt_left = {1'b0, b[6:0]} + 8'd1;
          pkt_run = b[7];
          if (eof) r.push_back(make_result(tga_pkg::KIND_STATUS, 0, 0, 0, 0,
                                           pkt_run ? tga_pkg::ST_RUN_CUT : tga_pkg::ST_RAW_CUT));
        end else if (32'(px_idx) + 1 >= 32'(bpp / 8)) begin
          if (bpp == tga_pkg::BPP_8) texel = {8'hff, b, b, b};
          else if (bpp == tga_pkg::BPP_24) texel = {8'hff, px_acc[7:0], px_acc[15:8], b};
          else texel = {b, px_acc[7:0], px_acc[15:8], px_acc[23:16]};
          px_idx = '0;
          px_acc = '0;
          if (rle && pkt_run) begin
            len = (32'(pkt_left) < px_left) ? 32'(pkt_left) : px_left;
            r.push_back(texel_run(texel, len));
            pkt_left = '0;
          end else begin
            r.push_back(texel_run(texel, 32'd1));
            if (rle) pkt_left = pkt_left - 8'd1;
          end
          if (px_left == 0) begin
            r.push_back(make_result(tga_pkg::KIND_STATUS, 0, 0, 0, 0, tga_pkg::ST_OK));
            dec_phase = tga_pkg::PH_DRAIN;
          end else if (eof) begin
            st = !rle ? tga_pkg::ST_TRUNCATED :
                 (pkt_left != 0 ? tga_pkg::ST_RAW_CUT : tga_pkg::ST_EARLY_END);
            r.push_back(make_result(tga_pkg::KIND_STATUS, 0, 0, 0, 0, st));
          end
        end else begin
          px_acc = px_acc | (24'(b) << (8 * px_idx));
          px_idx = px_idx + 2'd1;
          if (eof) begin
            st = !rle ? tga_pkg::ST_TRUNCATED :
                 (pkt_run ? tga_pkg::ST_RUN_CUT : tga_pkg::ST_RAW_CUT);
            r.push_back(make_result(tga_pkg::KIND_STATUS, 0, 0, 0, 0, st));
          end
        end
      end
      default: ;
    endcase
    if (r.size() > 0) r[r.size() - 1].last = 1'b1;
    foreach (r[i]) result_q.push_back(r[i]);
    if (eof) clear_decoder();
  endfunction

  // ---------------- file builder ----------------
  // cut < 0: whole file plus 0 to 3 trailing bytes; 0: random cut; > 0: that length, capped at the file size
  task automatic add_file(logic [7:0] kind, logic [7:0] depth, logic [15:0] w,
                          logic [15:0] h, int id_len, logic top, int cut,
                          logic cmap_b = 1'b0, bit hold = 0);
    logic [7:0] fb[$];
    int         npix;
    int         rem;
    int         cnt;
    int         nb;
    int         len;
    fb.push_back(8'(id_len));
    fb.push_back(cmap_b ? 8'($urandom_range(1, 255)) : 8'd0);
    fb.push_back(kind);
    for (int i = 3; i < 12; i++) fb.push_back(8'($urandom));
    fb.push_back(w[7:0]); fb.push_back(w[15:8]);
    fb.push_back(h[7:0]); fb.push_back(h[15:8]);
    fb.push_back(depth);
    fb.push_back((8'($urandom) & ~tga_pkg::TOP_ORIGIN_BIT) |
                 (top ? tga_pkg::TOP_ORIGIN_BIT : 8'h00));
    for (int i = 0; i < id_len; i++) fb.push_back(8'($urandom));
    npix = 32'(w) * 32'(h);
    if (npix > 40 || npix == 0) npix = 40;
    nb = (depth == tga_pkg::BPP_8) ? 1 : (depth == tga_pkg::BPP_24) ? 3 :
         (depth == tga_pkg::BPP_32) ? 4 : 1;
    rem = npix;
    while (rem > 0) begin
      if (kind == tga_pkg::TYPE_RLE) begin
        cnt = $urandom_range(1, (rem + 3 > 128) ? 128 : rem + 3);
        if ($urandom_range(0, 1)) begin
          fb.push_back(8'h80 | 8'(cnt - 1));
          for (int k = 0; k < nb; k++) fb.push_back(8'($urandom));
        end else begin
          fb.push_back(8'(cnt - 1));
          for (int p = 0; p < cnt; p++)
            for (int k = 0; k < nb; k++) fb.push_back(8'($urandom));
        end
        rem -= cnt;
      end else begin
        for (int k = 0; k < nb; k++) fb.push_back(8'($urandom));
        rem--;
      end
    end
    if (cut < 0) begin
      len = fb.size() + $urandom_range(0, 3);
      while (fb.size() < len) fb.push_back(8'($urandom));
    end else if (cut == 0) begin
      len = $urandom_range(1, fb.size());
    end else begin
      len = (cut < fb.size()) ? cut : fb.size();
    end
    for (int i = 0; i < len; i++)
      byte_q.push_back('{fb[i], i == len - 1, hold && i == 0});
  endtask

  // random format: mostly valid, sometimes broken
  task automatic add_random_file(bit hold);
    logic [7:0]  kind;
    logic [7:0]  depth;
    logic [15:0] w;
    logic [15:0] h;
    int          sel;
    int          cut;
    logic        cm;
    sel = $urandom_range(0, 2);
    kind = (sel == 0) ? tga_pkg::TYPE_TRUE : (sel == 1) ? tga_pkg::TYPE_GREY :
           tga_pkg::TYPE_RLE;
    sel = $urandom_range(0, 2);
    depth = (sel == 0) ? tga_pkg::BPP_8 : (sel == 1) ? tga_pkg::BPP_24 : tga_pkg::BPP_32;
    w = 16'($urandom_range(1, 6));
    h = 16'($urandom_range(1, 6));
    cm = 1'b0;
    cut = ($urandom_range(0, 3) == 0) ? 0 : -1;
    case ($urandom_range(0, 11))
      0: kind = 8'($urandom);
      1: depth = 8'($urandom);
      2: cm = 1'b1;
      3: if ($urandom_range(0, 1)) w = '0; else h = '0;
      4: begin
        w = 16'($urandom);
        h = 16'($urandom);
        cut = 0;
      end
      default: ;
    endcase
    add_file(kind, depth, w, h, $urandom_range(0, 1) ? 0 : $urandom_range(1, 3),
             $urandom_range(0, 1), cut, cm, hold);
  endtask

  // ---------------- stimulus ----------------
  initial begin
    int         files;
    logic [7:0] hdr[18];
    clear_decoder();
    // directed: a set of valid, cut and unsupported files
    add_file(tga_pkg::TYPE_TRUE, tga_pkg::BPP_24, 16'd2, 16'd2, 0, 1'b0, -1); // bottom origin
    add_file(tga_pkg::TYPE_GREY, tga_pkg::BPP_8, 16'd3, 16'd1, 2, 1'b1, -1);  // id, top origin
    add_file(tga_pkg::TYPE_TRUE, tga_pkg::BPP_32, 16'd1, 16'd2, 0, 1'b1, -1); // with alpha
    add_file(tga_pkg::TYPE_TRUE, tga_pkg::BPP_24, 16'd2, 16'd2, 0, 1'b0, 5);  // inside header
    add_file(tga_pkg::TYPE_TRUE, tga_pkg::BPP_24, 16'd2, 16'd2, 0, 1'b0, 18); // last hdr byte
    add_file(tga_pkg::TYPE_TRUE, tga_pkg::BPP_24, 16'd2, 16'd2, 3, 1'b0, 20); // inside id
    add_file(8'd1, tga_pkg::BPP_24, 16'd2, 16'd2, 0, 1'b0, 18);               // unsupported
    add_file(tga_pkg::TYPE_TRUE, tga_pkg::BPP_24, 16'd2, 16'd2, 0, 1'b0, 22); // truncated raw
    add_file(tga_pkg::TYPE_RLE, tga_pkg::BPP_8, 16'd16, 16'd9, 0, 1'b0, 20);  // rle, cut early
    add_file(tga_pkg::TYPE_RLE, tga_pkg::BPP_32, 16'hffff, 16'hffff, 0, 1'b1, 0); // huge size
    // longest run: 200 x 1 grey rle, a 128-texel run then a run clipped to 72
    hdr = '{8'd0, 8'd0, tga_pkg::TYPE_RLE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
            8'd0, 8'd0, 8'd200, 8'd0, 8'd1, 8'd0, tga_pkg::BPP_8, 8'd0};
    for (int i = 0; i < 18; i++) byte_q.push_back('{hdr[i], 1'b0, 1'b0});
    byte_q.push_back('{8'hff, 1'b0, 1'b0});
    byte_q.push_back('{8'h5a, 1'b0, 1'b0});
    byte_q.push_back('{8'hff, 1'b0, 1'b0});
    byte_q.push_back('{8'h33, 1'b0, 1'b0});
    byte_q.push_back('{8'hff, 1'b1, 1'b0});
    // random part
    files = 0;
    while (byte_q.size() < 1900) begin
      add_random_file(files == 30);
      files++;
    end
    stim_done = 1;
  end

  // ---------------- driver ----------------
  int  send_gap = 0;
  bit  send_burst = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) decode_byte(data_byte_i, end_of_file_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_q.size() > 0 && !(byte_q[0].hold &&
                     (result_q.size() > 0 || (in_valid_i && !in_stall_o)))) begin
          data_byte_i   <= byte_q[0].data;
          end_of_file_i <= byte_q[0].eof;
          in_valid_i    <= 1'b1;
          if (byte_q[0].eof) send_burst = ($urandom_range(0, 3) == 0);
          send_gap = send_burst ? 0 : $urandom_range(0, 19);
          void'(byte_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int  recv_gap = 0;
  bit  recv_burst = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    tga_result_t got;
    tga_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{item_kind_o, texel_o, start_x_o, start_y_o, run_length_o, rows_descend_o,
                image_width_o, image_height_o, status_o, last_of_step_o};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d", $time, got.kind);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp kind=%0d texel=%h x=%0d y=%0d len=%0d desc=%0b",
                     $time, want.kind, want.texel, want.x, want.y, want.len, want.desc);
            $display("    exp w=%0d h=%0d status=%0d last=%0b", want.w, want.h,
                     want.status, want.last);
            $display("    act kind=%0d texel=%h x=%0d y=%0d len=%0d desc=%0b",
                     got.kind, got.texel, got.x, got.y, got.len, got.desc);
            $display("    act w=%0d h=%0d status=%0d last=%0b", got.w, got.h,
                     got.status, got.last);
            fail_count++;
          end
        end
        if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 19);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------- run control ----------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done);
    while (byte_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && result_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 1000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
